### rtl/ttw_pkg.sv
// ttw_pkg: shared constants, command codes, control word type and microprogram
// for the text terminal writer. No dependencies.
package ttw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int CMD_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 4;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int DATA_W     = CHAR_W + 2 * IDX_W;
    localparam int UPC_W      = 5;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = CHAR_W'(8);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT         = 3'd0,
        CMD_WRITE_AT    = 3'd1,
        CMD_CLEAR       = 3'd2,
        CMD_SCROLL_UP   = 3'd3,
        CMD_SCROLL_DOWN = 3'd4,
        CMD_READ        = 3'd5
    } t_cmd;

    // microprogram step addresses
    localparam logic [UPC_W-1:0] U_RS0  = UPC_W'(0);   // clearing pass after reset
    localparam logic [UPC_W-1:0] U_IDLE = UPC_W'(1);
    localparam logic [UPC_W-1:0] U_PC0  = UPC_W'(2);   // printable character
    localparam logic [UPC_W-1:0] U_PC1  = UPC_W'(3);
    localparam logic [UPC_W-1:0] U_NL0  = UPC_W'(4);   // newline
    localparam logic [UPC_W-1:0] U_NL1  = UPC_W'(5);
    localparam logic [UPC_W-1:0] U_BS0  = UPC_W'(6);   // backspace
    localparam logic [UPC_W-1:0] U_BS1  = UPC_W'(7);
    localparam logic [UPC_W-1:0] U_WP0  = UPC_W'(8);   // write at position
    localparam logic [UPC_W-1:0] U_CL0  = UPC_W'(9);   // clear
    localparam logic [UPC_W-1:0] U_CL1  = UPC_W'(10);
    localparam logic [UPC_W-1:0] U_CL2  = UPC_W'(11);
    localparam logic [UPC_W-1:0] U_SU0  = UPC_W'(12);  // scroll up
    localparam logic [UPC_W-1:0] U_SU1  = UPC_W'(13);
    localparam logic [UPC_W-1:0] U_SU2  = UPC_W'(14);
    localparam logic [UPC_W-1:0] U_SU3  = UPC_W'(15);
    localparam logic [UPC_W-1:0] U_SU4  = UPC_W'(16);
    localparam logic [UPC_W-1:0] U_SD0  = UPC_W'(17);  // scroll down
    localparam logic [UPC_W-1:0] U_SD1  = UPC_W'(18);
    localparam logic [UPC_W-1:0] U_SD2  = UPC_W'(19);
    localparam logic [UPC_W-1:0] U_SD3  = UPC_W'(20);
    localparam logic [UPC_W-1:0] U_SD4  = UPC_W'(21);
    localparam logic [UPC_W-1:0] U_SD5  = UPC_W'(22);
    localparam logic [UPC_W-1:0] U_RD0  = UPC_W'(23);  // read cell
    localparam logic [UPC_W-1:0] U_RD1  = UPC_W'(24);
    localparam logic [UPC_W-1:0] U_NP0  = UPC_W'(25);  // unused command codes

    typedef enum logic [2:0] {
        C_NEXT,       // step + 1
        C_ALWAYS,     // jump to target
        C_DISPATCH,   // wait for a word, then jump to the command entry
        C_PTR_MORE,   // jump while pointer has not reached the limit
        C_COL_LAST,   // jump if cursor sits in the last column
        C_ROW_LAST    // jump if cursor sits in the last row
    } t_cond;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COPY_END,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        LIM_CELL_END,
        LIM_COPY_END,
        LIM_ZERO,
        LIM_ROW_END
    } t_lim;

    typedef enum logic [3:0] {
        MEM_NONE,
        MEM_RD_UP,        // read ptr + COLUMNS
        MEM_RD_PTR,       // read ptr
        MEM_RD_POS,       // read addressed cell
        MEM_WR_COPY_UP,   // ptr <= read data
        MEM_WR_COPY_DN,   // ptr + COLUMNS <= read data
        MEM_WR_ZERO_PTR,
        MEM_WR_CELL_CUR,
        MEM_WR_ZERO_CUR,
        MEM_WR_CELL_POS
    } t_mem_op;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_ADV,
        CUR_NL,
        CUR_BACK
    } t_cur_op;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ZERO,
        OUT_READ
    } t_out_op;

    typedef struct packed {
        t_cond            cond;
        logic [UPC_W-1:0] target;
        t_ptr_op          ptr_op;
        t_lim             lim;
        t_mem_op          mem_op;
        t_cur_op          cur_op;
        t_out_op          out_op;
    } t_uword;

    function automatic t_uword f_uw(t_cond c, logic [UPC_W-1:0] tgt, t_ptr_op p, t_lim l,
                                    t_mem_op m, t_cur_op cu, t_out_op o);
        t_uword w;
        w.cond   = c;
        w.target = tgt;
        w.ptr_op = p;
        w.lim    = l;
        w.mem_op = m;
        w.cur_op = cu;
        w.out_op = o;
        return w;
    endfunction

    // control store
    function automatic t_uword f_ucode(logic [UPC_W-1:0] upc);
        t_uword w;
        unique case (upc)
            U_RS0:  w = f_uw(C_PTR_MORE, U_RS0, PTR_INC, LIM_CELL_END,
                             MEM_WR_ZERO_PTR, CUR_HOLD, OUT_NONE);
            U_IDLE: w = f_uw(C_DISPATCH, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_NONE);
            U_PC0:  w = f_uw(C_COL_LAST, U_NL0, PTR_HOLD, LIM_ZERO,
                             MEM_WR_CELL_CUR, CUR_HOLD, OUT_NONE);
            U_PC1:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_ADV, OUT_ZERO);
            U_NL0:  w = f_uw(C_ROW_LAST, U_SU0, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_NL, OUT_NONE);
            U_NL1:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_ZERO);
            U_BS0:  w = f_uw(C_NEXT, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_BACK, OUT_NONE);
            U_BS1:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_WR_ZERO_CUR, CUR_HOLD, OUT_ZERO);
            U_WP0:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_WR_CELL_POS, CUR_HOLD, OUT_ZERO);
            U_CL0:  w = f_uw(C_NEXT, U_IDLE, PTR_ZERO, LIM_ZERO,
                             MEM_NONE, CUR_HOME, OUT_NONE);
            U_CL1:  w = f_uw(C_PTR_MORE, U_CL1, PTR_INC, LIM_CELL_END,
                             MEM_WR_ZERO_PTR, CUR_HOLD, OUT_NONE);
            U_CL2:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_ZERO);
            U_SU0:  w = f_uw(C_NEXT, U_IDLE, PTR_ZERO, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_NONE);
            U_SU1:  w = f_uw(C_NEXT, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_RD_UP, CUR_HOLD, OUT_NONE);
            // falls out with ptr at the first cell of the bottom row
            U_SU2:  w = f_uw(C_PTR_MORE, U_SU1, PTR_INC, LIM_COPY_END,
                             MEM_WR_COPY_UP, CUR_HOLD, OUT_NONE);
            U_SU3:  w = f_uw(C_PTR_MORE, U_SU3, PTR_INC, LIM_CELL_END,
                             MEM_WR_ZERO_PTR, CUR_HOLD, OUT_NONE);
            U_SU4:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_ZERO);
            U_SD0:  w = f_uw(C_NEXT, U_IDLE, PTR_COPY_END, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_NONE);
            U_SD1:  w = f_uw(C_NEXT, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_RD_PTR, CUR_HOLD, OUT_NONE);
            U_SD2:  w = f_uw(C_PTR_MORE, U_SD1, PTR_DEC, LIM_ZERO,
                             MEM_WR_COPY_DN, CUR_HOLD, OUT_NONE);
            U_SD3:  w = f_uw(C_NEXT, U_IDLE, PTR_ZERO, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_NONE);
            U_SD4:  w = f_uw(C_PTR_MORE, U_SD4, PTR_INC, LIM_ROW_END,
                             MEM_WR_ZERO_PTR, CUR_HOLD, OUT_NONE);
            U_SD5:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_ZERO);
            U_RD0:  w = f_uw(C_NEXT, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_RD_POS, CUR_HOLD, OUT_NONE);
            U_RD1:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_READ);
            U_NP0:  w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                             MEM_NONE, CUR_HOLD, OUT_ZERO);
            default: w = f_uw(C_ALWAYS, U_IDLE, PTR_HOLD, LIM_ZERO,
                              MEM_NONE, CUR_HOLD, OUT_NONE);
        endcase
        return w;
    endfunction

endpackage

### rtl/text_terminal_writer.sv
// text_terminal_writer: character-cell text buffer with teletype cursor and scroll.
// Microcoded sequencer over a single-port cell RAM; uses ttw_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   command | in        | i_valid / o_ready  | i_command i_char_code i_bg_index i_fg_index
//           |           |                    | i_column i_row
//   result  | out       | o_valid / i_ready  | o_cursor_column o_cursor_row o_cell_char
//           |           |                    | o_cell_bg o_cell_fg
//
// One word at a time; the cell RAM does one read or one write per microprogram step.
// A put in the last column wraps through the newline steps; a newline or wrap on the
// bottom row goes on to scroll up. Scroll up copies each cell up from the row below,
// scroll down copies cells down from the end backwards; each then blanks the freed row.
// Clear blanks every cell and homes the cursor. After reset a clearing pass runs with
// o_ready low. A result waiting on i_ready holds the sequencer at its final step.
module text_terminal_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_char_code,
    input  logic [3:0] i_bg_index,
    input  logic [3:0] i_fg_index,
    input  logic [6:0] i_column,
    input  logic [5:0] i_row,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_cursor_column,
    output logic [5:0] o_cursor_row,
    output logic [7:0] o_cell_char,
    output logic [3:0] o_cell_bg,
    output logic [3:0] o_cell_fg
);

    localparam int CELL_W = ttw_pkg::CELL_W;
    localparam int DATA_W = ttw_pkg::DATA_W;
    localparam int COL_W  = ttw_pkg::COL_W;
    localparam int ROW_W  = ttw_pkg::ROW_W;
    localparam int UPC_W  = ttw_pkg::UPC_W;

    logic [DATA_W-1:0] mem [ttw_pkg::CELL_COUNT];

    logic [UPC_W-1:0]  r_upc, n_upc;
    logic [CELL_W-1:0] r_ptr, n_ptr;
    logic [COL_W-1:0]  r_ccol, n_ccol;
    logic [ROW_W-1:0]  r_crow, n_crow;
    logic [2:0]        r_cmd;
    logic [7:0]        r_char;
    logic [3:0]        r_bg, r_fg;
    logic [6:0]        r_col;
    logic [5:0]        r_row;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_o_valid, n_o_valid;
    logic [COL_W-1:0]  r_o_col;
    logic [ROW_W-1:0]  r_o_row;
    logic [DATA_W-1:0] r_o_cell;

    ttw_pkg::t_uword   cw;
    logic              accept, stall, go, load_out;
    logic [UPC_W-1:0]  entry;
    logic              in_range;
    logic [CELL_W-1:0] pos_addr, cur_slot, ptr_up, lim_val;
    logic              we, re;
    logic [CELL_W-1:0] wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, packed_cell;

    assign cw       = ttw_pkg::f_ucode(r_upc);
    assign o_ready  = (cw.cond == ttw_pkg::C_DISPATCH);
    assign accept   = i_valid && o_ready;
    assign stall    = (cw.out_op != ttw_pkg::OUT_NONE) && r_o_valid && !i_ready;
    assign go       = !stall;
    assign load_out = (cw.out_op != ttw_pkg::OUT_NONE) && go;

    assign in_range = ({1'b0, r_col} < (COL_W + 1)'(ttw_pkg::COLUMNS)) &&
                      ({1'b0, r_row} < (ROW_W + 1)'(ttw_pkg::ROWS));
    assign pos_addr = CELL_W'(r_row) * CELL_W'(ttw_pkg::COLUMNS) + CELL_W'(r_col);
    assign cur_slot = CELL_W'(r_crow) * CELL_W'(ttw_pkg::COLUMNS) + CELL_W'(r_ccol);
    assign ptr_up   = r_ptr + CELL_W'(ttw_pkg::COLUMNS);
    assign packed_cell = {r_char, r_bg, r_fg};

    // command entry point
    always_comb begin
        unique case (i_command)
            ttw_pkg::CMD_PUT: begin
                if (i_char_code == ttw_pkg::CHAR_NEWLINE) begin
                    entry = ttw_pkg::U_NL0;
                end else if (i_char_code == ttw_pkg::CHAR_BACKSPACE) begin
                    entry = ttw_pkg::U_BS0;
                end else begin
                    entry = ttw_pkg::U_PC0;
                end
            end
            ttw_pkg::CMD_WRITE_AT:    entry = ttw_pkg::U_WP0;
            ttw_pkg::CMD_CLEAR:       entry = ttw_pkg::U_CL0;
            ttw_pkg::CMD_SCROLL_UP:   entry = ttw_pkg::U_SU0;
            ttw_pkg::CMD_SCROLL_DOWN: entry = ttw_pkg::U_SD0;
            ttw_pkg::CMD_READ:        entry = ttw_pkg::U_RD0;
            default:                  entry = ttw_pkg::U_NP0;
        endcase
    end

    always_comb begin
        unique case (cw.lim)
            ttw_pkg::LIM_CELL_END: lim_val = CELL_W'(ttw_pkg::CELL_COUNT - 1);
            ttw_pkg::LIM_COPY_END: lim_val = CELL_W'(ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS - 1);
            ttw_pkg::LIM_ROW_END:  lim_val = CELL_W'(ttw_pkg::COLUMNS - 1);
            default:               lim_val = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_upc = r_upc;
        if (cw.cond == ttw_pkg::C_DISPATCH) begin
            if (accept) begin
                n_upc = entry;
            end
        end else if (go) begin
            unique case (cw.cond)
                ttw_pkg::C_ALWAYS:   n_upc = cw.target;
                ttw_pkg::C_PTR_MORE: n_upc = (r_ptr != lim_val) ? cw.target : r_upc + 1'b1;
                ttw_pkg::C_COL_LAST:
                    n_upc = (r_ccol == COL_W'(ttw_pkg::COLUMNS - 1)) ? cw.target : r_upc + 1'b1;
                ttw_pkg::C_ROW_LAST:
                    n_upc = (r_crow == ROW_W'(ttw_pkg::ROWS - 1)) ? cw.target : r_upc + 1'b1;
                default:             n_upc = r_upc + 1'b1;
            endcase
        end
    end

    // sweep pointer
    always_comb begin
        n_ptr = r_ptr;
        if (go) begin
            unique case (cw.ptr_op)
                ttw_pkg::PTR_ZERO:     n_ptr = '0;
                ttw_pkg::PTR_COPY_END: n_ptr = CELL_W'(ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS - 1);
                ttw_pkg::PTR_INC:      n_ptr = r_ptr + 1'b1;
                ttw_pkg::PTR_DEC:      n_ptr = r_ptr - 1'b1;
                default:               n_ptr = r_ptr;
            endcase
        end
    end

    // cursor
    always_comb begin
        n_ccol = r_ccol;
        n_crow = r_crow;
        if (go) begin
            unique case (cw.cur_op)
                ttw_pkg::CUR_HOME: begin
                    n_ccol = '0;
                    n_crow = '0;
                end
                ttw_pkg::CUR_ADV: n_ccol = r_ccol + 1'b1;
                ttw_pkg::CUR_NL: begin
                    n_ccol = '0;
                    if (r_crow != ROW_W'(ttw_pkg::ROWS - 1)) begin
                        n_crow = r_crow + 1'b1;
                    end
                end
                ttw_pkg::CUR_BACK: begin
                    if (r_ccol != '0) begin
                        n_ccol = r_ccol - 1'b1;
                    end else if (r_crow != '0) begin
                        n_crow = r_crow - 1'b1;
                        n_ccol = COL_W'(ttw_pkg::COLUMNS - 1);
                    end
                end
                default: ;
            endcase
        end
    end

    // cell RAM ports
    always_comb begin
        we      = 1'b0;
        re      = 1'b0;
        wr_addr = r_ptr;
        rd_addr = r_ptr;
        wr_data = '0;
        unique case (cw.mem_op)
            ttw_pkg::MEM_RD_UP: begin
                re      = 1'b1;
                rd_addr = ptr_up;
            end
            ttw_pkg::MEM_RD_PTR: re = 1'b1;
            ttw_pkg::MEM_RD_POS: begin
                re      = in_range;
                rd_addr = pos_addr;
            end
            ttw_pkg::MEM_WR_COPY_UP: begin
                we      = 1'b1;
                wr_data = r_rd_data;
            end
            ttw_pkg::MEM_WR_COPY_DN: begin
                we      = 1'b1;
                wr_addr = ptr_up;
                wr_data = r_rd_data;
            end
            ttw_pkg::MEM_WR_ZERO_PTR: we = 1'b1;
            ttw_pkg::MEM_WR_CELL_CUR: begin
                we      = 1'b1;
                wr_addr = cur_slot;
                wr_data = packed_cell;
            end
            ttw_pkg::MEM_WR_ZERO_CUR: begin
                we      = 1'b1;
                wr_addr = cur_slot;
            end
            ttw_pkg::MEM_WR_CELL_POS: begin
                we      = in_range;
                wr_addr = pos_addr;
                wr_data = packed_cell;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we && go && i_rst_n) begin
            mem[wr_addr] <= wr_data;
        end
        if (re && go) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc     <= ttw_pkg::U_RS0;
            r_ptr     <= '0;
            r_ccol    <= '0;
            r_crow    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_upc     <= n_upc;
            r_ptr     <= n_ptr;
            r_ccol    <= n_ccol;
            r_crow    <= n_crow;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_char <= i_char_code;
            r_bg   <= i_bg_index;
            r_fg   <= i_fg_index;
            r_col  <= i_column;
            r_row  <= i_row;
        end
        if (load_out) begin
            r_o_col  <= n_ccol;
            r_o_row  <= n_crow;
            // cell fields are zero except for an in-range read
            r_o_cell <= (cw.out_op == ttw_pkg::OUT_READ && in_range &&
                         r_cmd == ttw_pkg::CMD_READ) ? r_rd_data : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_cursor_column = r_o_col;
    assign o_cursor_row    = r_o_row;
    assign o_cell_char     = r_o_cell[DATA_W-1 -: 8];
    assign o_cell_bg       = r_o_cell[7:4];
    assign o_cell_fg       = r_o_cell[3:0];

endmodule

### rtl/ttw_checker.sv
// ttw_checker: port-level assertions for text_terminal_writer, bound to the top level.
// Uses ttw_pkg for the buffer dimensions.
module ttw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [6:0] o_cursor_column,
    input logic [5:0] o_cursor_row,
    input logic [7:0] o_cell_char,
    input logic [3:0] o_cell_bg,
    input logic [3:0] o_cell_fg
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cursor_column) &&
        $stable(o_cursor_row) && $stable(o_cell_char) && $stable(o_cell_bg) &&
        $stable(o_cell_fg))
        else $error("result changed while stalled");

    // one word in flight: ready drops right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while one is in flight");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_cursor_column} < 8'(ttw_pkg::COLUMNS)) &&
                    ({1'b0, o_cursor_row} < 7'(ttw_pkg::ROWS)))
        else $error("cursor off screen");

    // clearing pass after reset: nothing offered, nothing taken
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("block active right after reset");

endmodule

bind text_terminal_writer ttw_checker u_ttw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_cursor_column(o_cursor_column),
    .o_cursor_row   (o_cursor_row),
    .o_cell_char    (o_cell_char),
    .o_cell_bg      (o_cell_bg),
    .o_cell_fg      (o_cell_fg)
);

### test/text_terminal_writer_tb.sv
// text_terminal_writer_tb: self-checking bench for the text terminal writer.
// Keeps its own copy of the screen and cursor to predict every result word.
// Depends on ttw_pkg and text_terminal_writer.
module text_terminal_writer_tb;

    localparam int COLUMNS    = ttw_pkg::COLUMNS;
    localparam int ROWS       = ttw_pkg::ROWS;
    localparam int CELL_COUNT = ttw_pkg::CELL_COUNT;
    localparam int CMD_W      = ttw_pkg::CMD_W;
    localparam int CHAR_W     = ttw_pkg::CHAR_W;
    localparam int IDX_W      = ttw_pkg::IDX_W;
    localparam int COL_W      = ttw_pkg::COL_W;
    localparam int ROW_W      = ttw_pkg::ROW_W;
    localparam int DATA_W     = ttw_pkg::DATA_W;

    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  bg;
        logic [IDX_W-1:0]  fg;
    } t_report;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [CMD_W-1:0]  i_command;
    logic [CHAR_W-1:0] i_char_code;
    logic [IDX_W-1:0]  i_bg_index;
    logic [IDX_W-1:0]  i_fg_index;
    logic [COL_W-1:0]  i_column;
    logic [ROW_W-1:0]  i_row;
    logic              o_valid;
    logic              i_ready;
    logic [COL_W-1:0]  o_cursor_column;
    logic [ROW_W-1:0]  o_cursor_row;
    logic [CHAR_W-1:0] o_cell_char;
    logic [IDX_W-1:0]  o_cell_bg;
    logic [IDX_W-1:0]  o_cell_fg;

    text_terminal_writer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_bg_index      (i_bg_index),
        .i_fg_index      (i_fg_index),
        .i_column        (i_column),
        .i_row           (i_row),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cell_char     (o_cell_char),
        .o_cell_bg       (o_cell_bg),
        .o_cell_fg       (o_cell_fg)
    );

    // shadow screen, cells packed as {char, bg, fg}
    logic [DATA_W-1:0] screen_cells [CELL_COUNT];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    t_report           pending_reports [$];
    int                mismatches = 0;
    int                valid_idle_pct = 0;
    int                ready_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    function automatic int cursor_index();
        return int'(cur_row) * COLUMNS + int'(cur_col);
    endfunction

    function automatic void clear_screen();
        foreach (screen_cells[i]) screen_cells[i] = '0;
        cur_col = '0;
        cur_row = '0;
    endfunction

    function automatic void shift_screen_up();
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_cells[i] = '0;
    endfunction

    // column 0 of the next row; scroll instead when already on the bottom row
    function automatic void cursor_line_feed();
        cur_col = '0;
        if (cur_row == ROW_W'(ROWS - 1)) shift_screen_up();
        else cur_row = cur_row + 1'b1;
    endfunction

    function automatic t_report update_screen(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                              logic [IDX_W-1:0] bg, logic [IDX_W-1:0] fg,
                                              logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        t_report rep;
        bit      in_range;
        int      addr;
        rep = '0;
        in_range = (col < COLUMNS) && (row < ROWS);
        addr = int'(row) * COLUMNS + int'(col);
        case (cmd)
            ttw_pkg::CMD_PUT: begin
                if (ch == ttw_pkg::CHAR_NEWLINE) begin
                    cursor_line_feed();
                end else if (ch == ttw_pkg::CHAR_BACKSPACE) begin
                    if (cur_col != 0) begin
                        cur_col = cur_col - 1'b1;
                    end else if (cur_row != 0) begin
                        cur_row = cur_row - 1'b1;
                        cur_col = COL_W'(COLUMNS - 1);
                    end
                    screen_cells[cursor_index()] = '0;
                end else begin
                    screen_cells[cursor_index()] = {ch, bg, fg};
                    if (cur_col < COLUMNS - 1) cur_col = cur_col + 1'b1;
                    else cursor_line_feed();
                end
            end
            ttw_pkg::CMD_WRITE_AT: begin
                if (in_range) screen_cells[addr] = {ch, bg, fg};
            end
            ttw_pkg::CMD_CLEAR: clear_screen();
            ttw_pkg::CMD_SCROLL_UP: shift_screen_up();
            ttw_pkg::CMD_SCROLL_DOWN: begin
                for (int i = CELL_COUNT - 1; i >= COLUMNS; i--) begin
                    screen_cells[i] = screen_cells[i - COLUMNS];
                end
                for (int i = 0; i < COLUMNS; i++) screen_cells[i] = '0;
            end
            ttw_pkg::CMD_READ: begin
                if (in_range) {rep.ch, rep.bg, rep.fg} = screen_cells[addr];
            end
            default: ;
        endcase
        rep.col = cur_col;
        rep.row = cur_row;
        return rep;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] bg, input logic [IDX_W-1:0] fg,
                             input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        @(negedge i_clk);
        if ($urandom_range(99) < valid_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < valid_idle_pct) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_char_code <= ch;
        i_bg_index  <= bg;
        i_fg_index  <= fg;
        i_column    <= col;
        i_row       <= row;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_reports.push_back(update_screen(cmd, ch, bg, fg, col, row));
    endtask

    // hold off the sender until every predicted word has come back
    task automatic wait_all_reports();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_position(output logic [COL_W-1:0] col, output logic [ROW_W-1:0] row);
        if ($urandom_range(99) < 15) begin
            col = COL_W'($urandom);
            row = ROW_W'($urandom);
        end else begin
            col = COL_W'($urandom_range(COLUMNS - 1));
            row = ROW_W'($urandom_range(ROWS - 1));
        end
    endtask

    function automatic void compare_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected word, expected none, got col %0d row %0d char %0d",
                         $time, o_cursor_column, o_cursor_row, o_cell_char);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                compare_field("cursor_column", 8'(want.col), 8'(o_cursor_column));
                compare_field("cursor_row", 8'(want.row), 8'(o_cursor_row));
                compare_field("cell_char", want.ch, o_cell_char);
                compare_field("cell_bg", 8'(want.bg), 8'(o_cell_bg));
                compare_field("cell_fg", 8'(want.fg), 8'(o_cell_fg));
            end
        end
    end

    // teletype path: extreme bytes, backspace in all its forms, newline, wrap
    task automatic test_terminal_put();
        send_word(ttw_pkg::CMD_PUT, 8'hFF, 4'hF, 4'hF, COL_W'($urandom), ROW_W'($urandom));
        send_word(ttw_pkg::CMD_PUT, 8'h00, 4'h0, 4'h0, COL_W'($urandom), ROW_W'($urandom));
        send_word(ttw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 7'd0, 6'd0);
        send_word(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_BACKSPACE, 4'h5, 4'hA, 7'd0, 6'd0);
        send_word(ttw_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 7'd1, 6'd0);
        send_word(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_BACKSPACE, 4'hA, 4'h5, 7'd0, 6'd0);
        // at home
        send_word(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_BACKSPACE, 4'h0, 4'h0, 7'd127, 6'd63);
        send_word(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_NEWLINE, 4'h3, 4'hC, 7'd0, 6'd0);
        // back to prior row
        send_word(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_BACKSPACE, 4'h0, 4'h0, 7'd0, 6'd0);
        send_word(ttw_pkg::CMD_PUT, 8'h7E, 4'h9, 4'h6, 7'd0, 6'd0);   // last column, wraps
        send_word(ttw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, COL_W'(COLUMNS - 1), 6'd0);
        wait_all_reports();
    endtask

    task automatic test_direct_access();
        send_word(ttw_pkg::CMD_WRITE_AT, 8'h5A, 4'h3, 4'hC, COL_W'(COLUMNS - 1),
                  ROW_W'(ROWS - 1));
        send_word(ttw_pkg::CMD_WRITE_AT, 8'hA5, 4'hF, 4'hF, 7'd127, 6'd63);
        send_word(ttw_pkg::CMD_WRITE_AT, 8'hA5, 4'hF, 4'hF, COL_W'(COLUMNS), 6'd0);
        send_word(ttw_pkg::CMD_WRITE_AT, 8'hA5, 4'hF, 4'hF, 7'd0, ROW_W'(ROWS));
        send_word(ttw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        send_word(ttw_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 7'd127, 6'd63);
        send_word(ttw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 7'd0, ROW_W'(ROWS));
        wait_all_reports();
    endtask

    task automatic test_scroll_and_clear();
        send_word(ttw_pkg::CMD_SCROLL_UP, 8'hFF, 4'hF, 4'hF, 7'd127, 6'd63);
        send_word(ttw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 2));
        send_word(ttw_pkg::CMD_SCROLL_DOWN, 8'h00, 4'h0, 4'h0, 7'd0, 6'd0);
        send_word(ttw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        send_word(CMD_UNUSED_6, 8'hFF, 4'hF, 4'hF, 7'd0, 6'd0);
        send_word(CMD_UNUSED_7, 8'h41, 4'h1, 4'h2, 7'd3, 6'd4);
        send_word(ttw_pkg::CMD_CLEAR, 8'h00, 4'h0, 4'h0, 7'd0, 6'd0);
        send_word(ttw_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        wait_all_reports();
    endtask

    // mostly lines of text ended by newline, mixed with direct access and rare
    // full-buffer commands, which cost a whole pass each
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int budget);
        int                sent;
        int                pick;
        int                burst_chars;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        valid_idle_pct  = idle_pct;
        ready_stall_pct = stall_pct;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                burst_chars = ($urandom_range(7) == 0) ? $urandom_range(82, 78)
                                                       : $urandom_range(20);
                repeat (burst_chars) begin
                    ch = ($urandom_range(11) == 0) ? ttw_pkg::CHAR_BACKSPACE : CHAR_W'($urandom);
                    send_word(ttw_pkg::CMD_PUT, ch, IDX_W'($urandom), IDX_W'($urandom),
                              COL_W'($urandom), ROW_W'($urandom));
                    sent++;
                end
                if ($urandom_range(4) != 0) begin
                    send_word(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_NEWLINE, IDX_W'($urandom),
                              IDX_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
                    sent++;
                end
            end else if (pick < 70) begin
                pick_position(col, row);
                send_word(ttw_pkg::CMD_WRITE_AT, CHAR_W'($urandom), IDX_W'($urandom),
                          IDX_W'($urandom), col, row);
                sent++;
            end else if (pick < 88) begin
                repeat ($urandom_range(3, 1)) begin
                    if ($urandom_range(1) == 0) begin
                        col = (cur_col == 0) ? cur_col : cur_col - 1'b1;
                        row = cur_row;
                    end else begin
                        pick_position(col, row);
                    end
                    send_word(ttw_pkg::CMD_READ, CHAR_W'($urandom), IDX_W'($urandom),
                              IDX_W'($urandom), col, row);
                    sent++;
                end
            end else begin
                if (pick < 92) send_word(ttw_pkg::CMD_SCROLL_UP, CHAR_W'($urandom),
                                         IDX_W'($urandom), IDX_W'($urandom),
                                         COL_W'($urandom), ROW_W'($urandom));
                else if (pick < 96) send_word(ttw_pkg::CMD_SCROLL_DOWN, CHAR_W'($urandom),
                                              IDX_W'($urandom), IDX_W'($urandom),
                                              COL_W'($urandom), ROW_W'($urandom));
                else if (pick < 98) send_word(ttw_pkg::CMD_CLEAR, CHAR_W'($urandom),
                                              IDX_W'($urandom), IDX_W'($urandom),
                                              COL_W'($urandom), ROW_W'($urandom));
                else send_word(($urandom_range(1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7,
                               CHAR_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                               COL_W'($urandom), ROW_W'($urandom));
                sent++;
            end
        end
        wait_all_reports();
    endtask

    // ends the run when no word moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = ttw_pkg::CMD_PUT;
        i_char_code = '0;
        i_bg_index  = '0;
        i_fg_index  = '0;
        i_column    = '0;
        i_row       = '0;
        clear_screen();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_terminal_put();
        test_direct_access();
        test_scroll_and_clear();
        test_random_traffic(0, 0, 257);
        test_random_traffic(81, 0, 257);
        test_random_traffic(0, 81, 257);
        test_random_traffic(12, 12, 257);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ttw_pkg.sv
rtl/text_terminal_writer.sv
rtl/ttw_checker.sv
test/text_terminal_writer_tb.sv
